// ----- src/mpd_pkg.sv -----
package mpd_pkg;

  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  localparam logic [3:0] ALLOWED_ERR_RESET = 4'd1;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_HEADER  = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_ETX_OK  = 3'd3,
    EV_FRAMING = 3'd4,
    EV_GOOD    = 3'd5,
    EV_BAD     = 3'd6
  } event_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] pay_byte;
    logic [7:0] pay_index;
    logic [7:0] csum;
    logic [3:0] bit_errs;
  } res_t;

  function automatic logic [3:0] bit_count8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

endpackage

// ----- src/mpd_in_stage.sv -----
module mpd_in_stage
  import mpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid;
  logic [7:0] data;

  // accept whenever the held word moves on or the register is empty
  assign in_stall   = valid && !advance;
  assign hold_valid = valid;
  assign hold_byte  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!in_stall) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data <= rx_byte;
    end
  end

endmodule

// ----- src/mpd_frame_core.sv -----
module mpd_frame_core
  import mpd_pkg::*;
#(
  parameter logic [7:0] LEN = 8'd64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [3:0] cfg_data,
  input  logic       advance,
  input  logic [7:0] byte_in,
  output res_t       res
);

  localparam logic [7:0] HEADER_SUM = SOH_BYTE + NUL_BYTE + LEN + STX_BYTE;

  logic [7:0] win0, win1, win2;
  logic [7:0] win0_next, win1_next, win2_next;
  logic       in_packet, in_packet_next;
  logic [7:0] byte_position, byte_position_next;
  logic [7:0] running_sum, running_sum_next;
  logic [3:0] allowed_bit_errors;
  logic [3:0] errs;

  assign errs = bit_count8(running_sum ^ byte_in);

  always_comb begin
    win0_next          = win0;
    win1_next          = win1;
    win2_next          = win2;
    in_packet_next     = in_packet;
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    res                = '0;
    res.ev             = EV_NONE;
    if (!in_packet) begin
      win0_next = win1;
      win1_next = win2;
      win2_next = byte_in;
      if (win0 == SOH_BYTE && win1 == NUL_BYTE && win2 == LEN && byte_in == STX_BYTE) begin
        in_packet_next     = 1'b1;
        byte_position_next = 8'd0;
        running_sum_next   = HEADER_SUM;
        res.ev             = EV_HEADER;
      end
    end else if (byte_position < LEN) begin
      res.ev             = EV_PAYLOAD;
      res.pay_byte       = byte_in;
      res.pay_index      = byte_position;
      running_sum_next   = running_sum + byte_in;
      byte_position_next = byte_position + 8'd1;
    end else if (byte_position == LEN) begin
      if (byte_in != ETX_BYTE) begin
        // drop the word, back to hunting
        res.ev             = EV_FRAMING;
        in_packet_next     = 1'b0;
        byte_position_next = 8'd0;
      end else begin
        res.ev             = EV_ETX_OK;
        running_sum_next   = running_sum + ETX_BYTE;
        byte_position_next = byte_position + 8'd1;
      end
    end else begin
      res.csum       = running_sum;
      res.bit_errs   = errs;
      res.ev         = (errs <= allowed_bit_errors) ? EV_GOOD : EV_BAD;
      in_packet_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win0          <= 8'd0;
      win1          <= 8'd0;
      win2          <= 8'd0;
      in_packet     <= 1'b0;
      byte_position <= 8'd0;
      running_sum   <= 8'd0;
    end else if (advance) begin
      win0          <= win0_next;
      win1          <= win1_next;
      win2          <= win2_next;
      in_packet     <= in_packet_next;
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allowed_bit_errors <= ALLOWED_ERR_RESET;
    end else if (cfg_write) begin
      allowed_bit_errors <= cfg_data;
    end
  end

endmodule

// ----- src/mpd_out_stage.sv -----
module mpd_out_stage
  import mpd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load_valid,
  input  res_t load_res,
  output logic ready,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  logic valid;
  res_t data;

  assign ready     = !valid || !out_stall;
  assign out_valid = valid;
  assign out_res   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load_valid) begin
      data <= load_res;
    end
  end

endmodule

// ----- src/meter_packet_deframer.sv -----
// Path: an accepted byte passes the input register, then the result register, before its result word is shown.
// Throughput: one byte per cycle while out_stall is low; the framing state updates once per byte in one step.
// Reset: synchronous, active high; clears the header window, packet state, position,
// running sum and both stage valids, and sets allowed_bit_errors to 1.
module meter_packet_deframer
  import mpd_pkg::*;
#(
  parameter int PAYLOAD_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_res,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index,
  output logic [7:0] computed_checksum,
  output logic [3:0] checksum_bit_errors
);

  localparam logic [7:0] LEN = PAYLOAD_LEN[7:0];

  logic       out_ready;
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       advance;
  res_t       core_res;
  res_t       out_res;

  assign advance = hold_valid && out_ready;

  mpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .advance    (out_ready),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  mpd_frame_core #(
    .LEN (LEN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .byte_in   (hold_byte),
    .res       (core_res)
  );

  mpd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (hold_valid),
    .load_res   (core_res),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign event_res           = out_res.ev;
  assign payload_byte        = out_res.pay_byte;
  assign payload_index       = out_res.pay_index;
  assign computed_checksum   = out_res.csum;
  assign checksum_bit_errors = out_res.bit_errs;

endmodule
